FILE: sv/fvn_pkg.sv
// Shared types, constants and table functions for the fractal value noise block.
package fvn_pkg;

  localparam int MAX_OCTAVES_DEF       = 8;
  localparam int COORD_FRAC_BITS_DEF   = 16;
  localparam int WEIGHT_TABLE_BITS_DEF = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int COORD_W     = 32;
  localparam int OCT_W       = 5;
  localparam int SEED_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int WEIGHT_W    = 17;
  localparam int AMP_W       = 17;
  localparam int LAT_W       = 32;
  localparam int SMOOTH_W    = 36;
  localparam int PROD_W      = 54;
  localparam int ACC_W       = 58;
  localparam int OUT_W       = 25;
  localparam int NUM_POINTS  = 16;
  localparam int NUM_CORNERS = 4;

  localparam logic [AMP_W-1:0] AMP_ONE     = 17'd65536;
  localparam logic [31:0]      HASH_MASK   = 32'h7fffffff;
  localparam logic [31:0]      HASH_MUL_Y  = 32'd57;
  localparam int               HASH_SHIFT  = 13;
  localparam logic [31:0]      LAT_ONE     = 32'd1073741824;
  localparam logic [ACC_W-1:0] ROUND_HALF  = ACC_W'(64'd536870912);
  localparam int               OUT_SHIFT   = 30;
  localparam logic signed [ACC_W-31:0] OUT_MAX = 28'sd8388608;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_OCTAVES = 2'd0,
    REG_SEED        = 2'd1,
    REG_PERSISTENCE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } coord_t;

  typedef struct packed {
    logic [OCT_W-1:0]  oct;
    logic [SEED_W-1:0] seed;
    logic [AMP_W-1:0]  pers;
  } cfg_t;

  typedef struct packed {
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
  } coef_t;

  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic                zero;
    logic [WEIGHT_W-1:0] wx;
    logic [WEIGHT_W-1:0] wy;
    logic [AMP_W-1:0]    amp;
  } beat_t;

  function automatic coef_t hash_coef(input logic [3:0] set);
    coef_t c;
    case (set)
      4'd0:    c = '{32'd995615039, 32'd600173719, 32'd701464987};
      4'd1:    c = '{32'd831731269, 32'd162318869, 32'd136250887};
      4'd2:    c = '{32'd174329291, 32'd946737083, 32'd245679977};
      4'd3:    c = '{32'd362489573, 32'd795918041, 32'd350777237};
      4'd4:    c = '{32'd457025711, 32'd880830799, 32'd909678923};
      4'd5:    c = '{32'd787070341, 32'd177340217, 32'd593320781};
      4'd6:    c = '{32'd405493717, 32'd291031019, 32'd391950901};
      4'd7:    c = '{32'd458904767, 32'd676625681, 32'd424452397};
      4'd8:    c = '{32'd531736441, 32'd939683957, 32'd810651871};
      4'd9:    c = '{32'd997169939, 32'd842027887, 32'd423882827};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd30) r = r - 6'd30;
    else if (r >= 6'd20) r = r - 6'd20;
    else if (r >= 6'd10) r = r - 6'd10;
    return r[3:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] wrom_entry(input int k, input int wbits);
    logic [63:0]        phi;
    logic [63:0]        phi2;
    logic [63:0]        term;
    logic [63:0]        f;
    logic signed [63:0] s;
    phi  = (HALF_PI_Q30 * 64'(k)) >> wbits;
    phi2 = (phi * phi) >> 30;
    term = phi;
    s    = signed'(phi);
    for (int n = 1; n <= 8; n++) begin
      term = (term * phi2) >> 30;
      term = term / SERIES_DIV[n-1];
      if (n % 2 == 1) s = s - signed'(term);
      else s = s + signed'(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    f = (unsigned'(s) * unsigned'(s)) >> 30;
    return WEIGHT_W'((f + 64'd8192) >> 14);
  endfunction

endpackage

FILE: sv/fractal_value_noise_2d.sv
// Top level of the fractal value noise block: configuration registers, front queue, back engine.
//
//  channel   signals                               direction  when taken
//  input     start, busy, coord_x, coord_y         in         start && !busy at clk
//  result    done, noise_value                     out        every cycle done is high
//  config    cfg_wen, cfg_index, cfg_data          in         cfg_wen at clk
//
// The octave engine issues one octave per cycle while the queue holds an item, so an item
// holds the engine for max(num_octaves,1) octaves (clamped to MAX_OCTAVES) before the next one.
// busy rises only when the queue is full; the result side never stalls.
// rst clears the queue, the sequencer and the configuration to its reset values.
module fractal_value_noise_2d import fvn_pkg::*; #(
  parameter int MAX_OCTAVES       = MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS   = COORD_FRAC_BITS_DEF,
  parameter int WEIGHT_TABLE_BITS = WEIGHT_TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_W-1:0]      coord_x,
  input  logic [COORD_W-1:0]      coord_y,
  output logic                    done,
  output logic signed [OUT_W-1:0] noise_value,
  input  logic                    cfg_wen,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [3:0]        num_octaves;
  logic [SEED_W-1:0] prime_seed_index;
  logic [AMP_W-1:0]  persistence;
  cfg_t              cfg;
  logic              head_valid;
  coord_t            head;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_octaves      <= 4'd4;
      prime_seed_index <= '0;
      persistence      <= AMP_W'(32768);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_NUM_OCTAVES: num_octaves      <= cfg_data[3:0];
        REG_SEED:        prime_seed_index <= cfg_data[SEED_W-1:0];
        REG_PERSISTENCE: persistence      <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.oct  = (int'(num_octaves) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES) : OCT_W'(num_octaves);
    cfg.seed = prime_seed_index;
    cfg.pers = (persistence > AMP_ONE) ? AMP_ONE : persistence;
  end

  fvn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  fvn_back #(
    .COORD_FRAC_BITS   (COORD_FRAC_BITS),
    .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .noise_value (noise_value)
  );

endmodule

FILE: sv/fvn_front.sv
// Front end: accepts coordinate beats into a short queue ahead of the octave engine.
module fvn_front import fvn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  output logic               busy,
  output logic               head_valid,
  output coord_t             head,
  input  logic               pop
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  coord_t           q [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic [QAW:0]     count_next;
  logic             push;
  logic             do_pop;

  assign busy       = (count == (QAW+1)'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !do_pop) count_next = count + 1'b1;
    else if (!push && do_pop) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{cx: coord_x, cy: coord_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !do_pop |=> count == $past(count) + 1'b1) else $error("push lost");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop && !push |=> count == $past(count) - 1'b1) else $error("pop lost");

endmodule

FILE: sv/fvn_back.sv
// Back end: octave sequencer, lattice hash pipeline, cosine blend and accumulator.
module fvn_back import fvn_pkg::*; #(
  parameter int COORD_FRAC_BITS   = COORD_FRAC_BITS_DEF,
  parameter int WEIGHT_TABLE_BITS = WEIGHT_TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    head_valid,
  input  coord_t                  head,
  output logic                    pop,
  output logic                    done,
  output logic signed [OUT_W-1:0] noise_value
);

  localparam int CFB     = COORD_FRAC_BITS;
  localparam int WTB     = WEIGHT_TABLE_BITS;
  localparam int WT_SIZE = 1 << WTB;

  logic [WEIGHT_W-1:0] wtab [WT_SIZE];

  for (genvar k = 0; k < WT_SIZE; k++) begin : g_wrom
    assign wtab[k] = wrom_entry(k, WTB);
  end

  logic [OCT_W-1:0]   beat_idx;
  logic [OCT_W-1:0]   oct_n;
  logic [OCT_W-1:0]   sh;
  logic               is_last;
  logic [AMP_W-1:0]   amp_reg;
  logic [AMP_W-1:0]   amp_cur;
  logic [2*AMP_W:0]   amp_prod;
  logic [COORD_W-1:0] sx;
  logic [COORD_W-1:0] sy;
  logic [CFB-1:0]     fx;
  logic [CFB-1:0]     fy;
  logic [WTB-1:0]     kx;
  logic [WTB-1:0]     ky;
  logic [3:0]         set;

  assign oct_n    = (cfg.oct == '0) ? OCT_W'(1) : cfg.oct;
  assign is_last  = (beat_idx == oct_n - 1'b1);
  assign pop      = head_valid && is_last;
  assign sh       = (cfg.oct == '0) ? '0 : cfg.oct - 1'b1 - beat_idx;
  assign sx       = head.cx >> sh;
  assign sy       = head.cy >> sh;
  assign fx       = sx[CFB-1:0];
  assign fy       = sy[CFB-1:0];
  assign set      = mod10(6'(cfg.seed) + 6'(beat_idx));
  assign amp_prod = (2*AMP_W+1)'(amp_reg) * (2*AMP_W+1)'(cfg.pers) + (2*AMP_W+1)'(32768);
  assign amp_cur  = (beat_idx == '0) ? cfg.pers : AMP_W'(amp_prod >> 16);

  if (CFB >= WTB) begin : g_kshr
    assign kx = fx[CFB-1 -: WTB];
    assign ky = fy[CFB-1 -: WTB];
  end else begin : g_kshl
    assign kx = WTB'({fx, {(WTB-CFB){1'b0}}});
    assign ky = WTB'({fy, {(WTB-CFB){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx <= '0;
      amp_reg  <= '0;
    end else if (head_valid) begin
      beat_idx <= is_last ? '0 : beat_idx + 1'b1;
      amp_reg  <= amp_cur;
    end
  end

  beat_t               b0, b1, b2, b3, b4, b5, b6, b7, b8;
  logic [31:0]         ix0, iy0;
  coef_t               cf0, cf1, cf2, cf3;
  logic [31:0]         n1  [NUM_POINTS];
  logic [31:0]         n2  [NUM_POINTS];
  logic [31:0]         sq2 [NUM_POINTS];
  logic [31:0]         n3  [NUM_POINTS];
  logic [31:0]         m3  [NUM_POINTS];
  logic [31:0]         t4  [NUM_POINTS];
  logic signed [LAT_W-1:0]    lv5 [NUM_POINTS];
  logic signed [SMOOTH_W-1:0] c6  [NUM_CORNERS];
  logic signed [SMOOTH_W-1:0] rx7 [2];
  logic signed [SMOOTH_W-1:0] v8;
  logic signed [PROD_W-1:0]   p9;
  logic                       p9_valid, p9_first, p9_last;
  logic signed [ACC_W-1:0]    acc;

  logic [31:0]                n_c  [NUM_POINTS];
  logic signed [SMOOTH_W-1:0] c_c  [NUM_CORNERS];
  logic signed [SMOOTH_W-1:0] rx_c [2];
  logic signed [SMOOTH_W-1:0] v_c;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [ACC_W-31:0]   res_c;
  logic signed [OUT_W-1:0]    sat_c;

  function automatic logic signed [SMOOTH_W-1:0] sext(input logic signed [LAT_W-1:0] a);
    return {{(SMOOTH_W-LAT_W){a[LAT_W-1]}}, a};
  endfunction

  function automatic logic signed [SMOOTH_W-1:0] blend(
    input logic signed [SMOOTH_W-1:0] lo,
    input logic signed [SMOOTH_W-1:0] hi,
    input logic [WEIGHT_W-1:0]        w
  );
    logic signed [SMOOTH_W:0]            d;
    logic signed [WEIGHT_W:0]            ws;
    logic signed [SMOOTH_W+WEIGHT_W+1:0] pr;
    d  = {hi[SMOOTH_W-1], hi} - {lo[SMOOTH_W-1], lo};
    ws = {1'b0, w};
    pr = d * ws;
    return lo + SMOOTH_W'(pr >>> 16);
  endfunction

  always_comb begin
    for (int p = 0; p < NUM_POINTS; p++) begin
      logic [31:0] x, y, n;
      x = ix0 + 32'((p % 4) - 1);
      y = iy0 + 32'((p / 4) - 1);
      n = x + y * HASH_MUL_Y;
      n_c[p] = (n << HASH_SHIFT) ^ n;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      int px, py;
      px = (c % 2) + 1;
      py = (c / 2) + 1;
      c_c[c] = sext(lv5[(py-1)*4 + px-1]) + sext(lv5[(py-1)*4 + px+1])
             + sext(lv5[(py+1)*4 + px-1]) + sext(lv5[(py+1)*4 + px+1])
             + ((sext(lv5[py*4 + px-1]) + sext(lv5[py*4 + px+1])
             + sext(lv5[(py-1)*4 + px]) + sext(lv5[(py+1)*4 + px])) <<< 1)
             + (sext(lv5[py*4 + px]) <<< 2);
    end
    rx_c[0] = blend(c6[0], c6[1], b6.wx);
    rx_c[1] = blend(c6[2], c6[3], b6.wx);
    v_c     = blend(rx7[0], rx7[1], b7.wy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= '0; b1 <= '0; b2 <= '0; b3 <= '0; b4 <= '0;
      b5 <= '0; b6 <= '0; b7 <= '0; b8 <= '0;
    end else begin
      b0 <= '{valid: head_valid, first: (beat_idx == '0), last: is_last,
              zero: (cfg.oct == '0), wx: wtab[kx], wy: wtab[ky], amp: amp_cur};
      b1 <= b0; b2 <= b1; b3 <= b2; b4 <= b3;
      b5 <= b4; b6 <= b5; b7 <= b6; b8 <= b7;
    end
  end

  always_ff @(posedge clk) begin
    ix0 <= sx >> CFB;
    iy0 <= sy >> CFB;
    cf0 <= hash_coef(set);
    cf1 <= cf0;
    cf2 <= cf1;
    cf3 <= cf2;
    for (int p = 0; p < NUM_POINTS; p++) begin
      n1[p]  <= n_c[p];
      n2[p]  <= n1[p];
      sq2[p] <= n1[p] * n1[p];
      n3[p]  <= n2[p];
      m3[p]  <= sq2[p] * cf2.c0 + cf2.c1;
      t4[p]  <= (n3[p] * m3[p] + cf3.c2) & HASH_MASK;
      lv5[p] <= signed'(LAT_ONE - t4[p]);
    end
    for (int c = 0; c < NUM_CORNERS; c++) begin
      c6[c] <= c_c[c];
    end
    rx7[0] <= rx_c[0];
    rx7[1] <= rx_c[1];
    v8     <= v_c;
    p9     <= b8.zero ? '0 : PROD_W'(v8) * PROD_W'(signed'({1'b0, b8.amp}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p9_valid <= 1'b0;
      p9_first <= 1'b0;
      p9_last  <= 1'b0;
    end else begin
      p9_valid <= b8.valid;
      p9_first <= b8.first;
      p9_last  <= b8.last;
    end
  end

  always_comb begin
    acc_sum = (p9_first ? '0 : acc) + ACC_W'(p9);
    res_c   = (ACC_W-30)'((acc_sum + signed'(ROUND_HALF)) >>> OUT_SHIFT);
    if (res_c > OUT_MAX) sat_c = OUT_W'(OUT_MAX);
    else if (res_c < -OUT_MAX) sat_c = OUT_W'(-OUT_MAX);
    else sat_c = OUT_W'(res_c);
  end

  always_ff @(posedge clk) begin
    if (p9_valid) acc <= acc_sum;
    if (p9_valid && p9_last) noise_value <= sat_c;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= p9_valid && p9_last;
  end

  a_first_amp: assert property (@(posedge clk) disable iff (rst)
    head_valid && beat_idx == '0 |-> amp_cur == cfg.pers) else $error("first amp");
  a_amp_falls: assert property (@(posedge clk) disable iff (rst)
    head_valid && beat_idx != '0 |-> amp_cur <= amp_reg) else $error("amp grew");
  a_beat_bound: assert property (@(posedge clk) disable iff (rst)
    beat_idx < oct_n || !head_valid) else $error("beat index past octave count");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(p9_valid) && $past(p9_last)) else $error("stray result");

endmodule

FILE: verif/tb_fractal_value_noise_2d.sv
// Self-checking testbench for fractal_value_noise_2d with a built-in noise predictor.
module tb_fractal_value_noise_2d;
  import fvn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1440;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    int unsigned oct;
    int unsigned seed;
    int unsigned pers;
    logic [31:0] x;
    logic [31:0] y;
    bit          fixed;
    logic signed [OUT_W-1:0] value;
  } stim_row_t;

  logic clk, rst, start, busy, done, cfg_wen;
  logic [COORD_W-1:0] coord_x, coord_y;
  logic signed [OUT_W-1:0] noise_value;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fractal_value_noise_2d uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .done(done), .noise_value(noise_value),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bit [31:0] prime_tab [10][3] = '{
    '{32'd995615039, 32'd600173719, 32'd701464987},
    '{32'd831731269, 32'd162318869, 32'd136250887},
    '{32'd174329291, 32'd946737083, 32'd245679977},
    '{32'd362489573, 32'd795918041, 32'd350777237},
    '{32'd457025711, 32'd880830799, 32'd909678923},
    '{32'd787070341, 32'd177340217, 32'd593320781},
    '{32'd405493717, 32'd291031019, 32'd391950901},
    '{32'd458904767, 32'd676625681, 32'd424452397},
    '{32'd531736441, 32'd939683957, 32'd810651871},
    '{32'd997169939, 32'd842027887, 32'd423882827}
  };

  bit [16:0] blend_rom [256];
  int unsigned octaves_reg = 4, seed_reg = 0, pers_reg = 32768;
  logic signed [OUT_W-1:0] noise_q [$];
  int mismatches = 0, checked = 0, cycles = 0, burst_left = 0, sent = 0, settings = 0;

  stim_row_t rows [] = '{
    '{4, 0, 32768, 32'h00000000, 32'h00000000, 1'b0, '0},
    '{4, 0, 32768, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{4, 0, 32768, 32'h0000FFFF, 32'hFFFF0000, 1'b0, '0},
    '{4, 0, 32768, 32'h00008000, 32'h00018000, 1'b0, '0},
    '{0, 0, 32768, 32'h12345678, 32'h9ABCDEF0, 1'b1, '0},
    '{0, 0, 32768, 32'hFFFFFFFF, 32'h00000000, 1'b1, '0},
    '{1, 0, 65536, 32'h00000000, 32'h00000000, 1'b0, '0},
    '{1, 9, 65536, 32'hFFFFFFFF, 32'h00000000, 1'b0, '0},
    '{8, 9, 65536, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{8, 9, 65536, 32'h7FFF00FF, 32'h80000100, 1'b0, '0},
    '{15, 15, 131071, 32'hABCD1234, 32'h5678EF01, 1'b0, '0},
    '{9, 10, 65537, 32'h00010000, 32'hFFFEFFFF, 1'b0, '0},
    '{8, 3, 0, 32'hDEADBEEF, 32'h01234567, 1'b1, '0},
    '{2, 12, 1, 32'h0000FF00, 32'h000000FF, 1'b0, '0},
    '{1, 5, 65536, 32'h7FFF0000, 32'h0000FFFF, 1'b0, '0},
    '{3, 7, 40000, 32'h00000001, 32'hFFFFFFFE, 1'b0, '0}
  };

  function automatic void build_blend_rom();
    longint unsigned phi, phi2, term, f;
    longint s;
    for (int k = 0; k < 256; k++) begin
      phi = (64'd1686629713 * longint'(k)) >> 8;
      phi2 = (phi * phi) >> 30;
      term = phi;
      s = phi;
      for (int n = 1; n <= 8; n++) begin
        term = (term * phi2) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      f = (longint'(s) * longint'(s)) >> 30;
      blend_rom[k] = 17'((f + 64'd8192) >> 14);
    end
  endfunction

  function automatic longint lattice_point(int set, bit [31:0] x, bit [31:0] y);
    bit [31:0] n, t;
    n = x + y * 32'd57;
    n = (n << 13) ^ n;
    t = (n * (n * n * prime_tab[set][0] + prime_tab[set][1]) + prime_tab[set][2])
        & 32'h7fffffff;
    return 64'sd1073741824 - longint'({32'b0, t});
  endfunction

  function automatic longint smoothed_point(int set, bit [31:0] x, bit [31:0] y);
    longint diag, side;
    diag = lattice_point(set, x - 1, y - 1) + lattice_point(set, x + 1, y - 1) +
           lattice_point(set, x - 1, y + 1) + lattice_point(set, x + 1, y + 1);
    side = lattice_point(set, x - 1, y) + lattice_point(set, x + 1, y) +
           lattice_point(set, x, y - 1) + lattice_point(set, x, y + 1);
    return diag + 2 * side + 4 * lattice_point(set, x, y);
  endfunction

  function automatic longint cosine_mix(longint lo, longint hi, bit [16:0] w);
    longint wl;
    wl = w;
    return lo + (((hi - lo) * wl) >>> 16);
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_noise(bit [31:0] cx, bit [31:0] cy);
    int unsigned oct, sh, set;
    longint unsigned pers, amp;
    longint acc, res, rx0, rx1, v;
    bit [31:0] sx, sy, ix, iy;
    bit [16:0] wx, wy;
    oct = octaves_reg > 8 ? 8 : octaves_reg;
    pers = pers_reg > 65536 ? 65536 : pers_reg;
    amp = 65536;
    acc = 0;
    for (int unsigned i = 0; i < oct; i++) begin
      sh = oct - 1 - i;
      set = (seed_reg + i) % 10;
      sx = cx >> sh;
      sy = cy >> sh;
      ix = sx >> 16;
      iy = sy >> 16;
      wx = blend_rom[sx[15:8]];
      wy = blend_rom[sy[15:8]];
      rx0 = cosine_mix(smoothed_point(set, ix, iy), smoothed_point(set, ix + 1, iy), wx);
      rx1 = cosine_mix(smoothed_point(set, ix, iy + 1),
                       smoothed_point(set, ix + 1, iy + 1), wx);
      v = cosine_mix(rx0, rx1, wy);
      amp = (amp * pers + 32768) >> 16;
      acc += v * longint'(amp);
    end
    res = (acc + (64'sd1 <<< 29)) >>> 30;
    if (res > 64'sd8388608) res = 64'sd8388608;
    if (res < -64'sd8388608) res = -64'sd8388608;
    return res[OUT_W-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst && done) begin
      if (noise_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: noise_value=%0d", noise_value);
      end else begin
        logic signed [OUT_W-1:0] want;
        want = noise_q.pop_front();
        checked++;
        if (noise_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d, got %0d", want, noise_value);
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned oct, int unsigned seed, int unsigned pers);
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (noise_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_NUM_OCTAVES, oct);
    write_reg(REG_SEED, seed);
    write_reg(REG_PERSISTENCE, pers);
    octaves_reg = oct;
    seed_reg = seed;
    pers_reg = pers;
    settings++;
  endtask

  task automatic send_item(logic [31:0] x, logic [31:0] y, bit fixed,
                           logic signed [OUT_W-1:0] value);
    bit take;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    do begin
      @(negedge clk);
      take = !busy;
      @(posedge clk);
    end while (!take);
    noise_q.push_back(fixed ? value : predict_noise(x, y));
    burst_left--;
    sent++;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3) << 16 | $urandom_range(0, 65535);
      1: return 32'hFFFFFFFF - $urandom_range(0, 200000);
      2: return (32'($urandom_range(0, 65535)) << 16) |
                ($urandom_range(0, 1) ? 32'h0000FFFF : 32'h00000000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned oct, seed, pers;
    rst = 1'b1;
    start = 1'b0;
    coord_x = '0;
    coord_y = '0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    build_blend_rom();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= '1;
    @(posedge clk);
    cfg_wen <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].oct != octaves_reg || rows[r].seed != seed_reg || rows[r].pers != pers_reg)
        apply_settings(rows[r].oct, rows[r].seed, rows[r].pers);
      send_item(rows[r].x, rows[r].y, rows[r].fixed, rows[r].value);
    end

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin oct = 8; seed = 9; pers = 65536; end
        1: begin oct = 1; seed = 0; pers = 0; end
        2: begin oct = 15; seed = 15; pers = 131071; end
        default: begin
          oct = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          seed = $urandom_range(0, 15);
          pers = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                             : $urandom_range(0, 65536);
        end
      endcase
      apply_settings(oct, seed, pers);
      for (int k = 0; k < RANDOM_ITEMS / 12; k++) send_item(pick_coord(), pick_coord(), 1'b0, '0);
    end

    start <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d coordinate pairs over %0d register settings.", sent, settings);
    $display("Checked %0d noise results, %0d mismatches.", checked, mismatches);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: fractal_value_noise_2d.f
sv/fvn_pkg.sv
sv/fvn_front.sv
sv/fvn_back.sv
sv/fractal_value_noise_2d.sv
verif/tb_fractal_value_noise_2d.sv
